@@ rtl/tksh_pkg.sv @@
`default_nettype none
package tksh_pkg;

   localparam int VALUE_W = 32;
   localparam int KEEP_W  = 6;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(32);

   // register index, taken from the word address bit of paddr
   localparam logic CSR_IDX_KEEP = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TRIM,
      ST_POP_LD,
      ST_DN_RD,
      ST_DN_CMP
   } state_type;

   typedef struct packed {
      logic load_item;   // capture value, pos = fill, fill + 1
      logic rd_parent;   // read parent of pos
      logic up_step;     // move parent down into pos, climb
      logic wr_carry;    // store carried value at pos
      logic pop_start;   // read root and last leaf, fill - 1
      logic pop_load;    // take root, carry the last leaf, pos = 0
      logic emit;        // root of this pop goes out as a word
      logic rd_kids;     // read both children of pos
      logic dn_step;     // move larger child up into pos, descend
   } cmd_type;

   typedef struct packed {
      logic pos_zero;
      logic up_greater;
      logic kid_in;
      logic dn_stop;
      logic over_limit;
      logic fill_nonzero;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/tksh_if.sv @@
`default_nettype none
interface tksh_req_if;
   import tksh_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      set_end;

   modport source (output valid, output value, output set_end, input ready);
   modport sink (input valid, input value, input set_end, output ready);
endinterface

interface tksh_rsp_if;
   import tksh_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] kept_value;
   logic                      run_end;

   modport source (output valid, output kept_value, output run_end, input ready);
   modport sink (input valid, input kept_value, input run_end, output ready);
endinterface
`default_nettype wire

@@ rtl/tksh_ctrl.sv @@
`default_nettype none
module tksh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_set_end,
   output logic                 req_ready,
   input  tksh_pkg::status_type status,
   output tksh_pkg::cmd_type    cmd
);
   import tksh_pkg::*;

   state_type state_ff, state_in;
   logic      set_end_ff, set_end_in;
   logic      emit_ff, emit_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         set_end_ff <= 1'b0;
         emit_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         set_end_ff <= set_end_in;
         emit_ff    <= emit_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UP_RD;
         end
         ST_UP_RD: begin
            state_in = status.pos_zero ? ST_TRIM : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = status.up_greater ? ST_UP_RD : ST_TRIM;
         end
         ST_TRIM: begin
            priority if (status.over_limit) begin
               state_in = ST_POP_LD;
            end else if (set_end_ff && status.fill_nonzero) begin
               if (status.out_free) state_in = ST_POP_LD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_LD: begin
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            state_in = status.kid_in ? ST_DN_CMP : ST_TRIM;
         end
         ST_DN_CMP: begin
            state_in = status.dn_stop ? ST_TRIM : ST_DN_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      set_end_in = set_end_ff;
      emit_in    = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               set_end_in    = req_set_end;
            end
         end
         ST_UP_RD: begin
            if (status.pos_zero) cmd.wr_carry = 1'b1;
            else cmd.rd_parent = 1'b1;
         end
         ST_UP_CMP: begin
            if (status.up_greater) cmd.up_step = 1'b1;
            else cmd.wr_carry = 1'b1;
         end
         ST_TRIM: begin
            priority if (status.over_limit) begin
               cmd.pop_start = 1'b1;
               emit_in       = 1'b0;
            end else if (set_end_ff && status.fill_nonzero) begin
               if (status.out_free) begin
                  cmd.pop_start = 1'b1;
                  emit_in       = 1'b1;
               end
            end else begin
               set_end_in = 1'b0;
            end
         end
         ST_POP_LD: begin
            cmd.pop_load = 1'b1;
            cmd.emit     = emit_ff;
         end
         ST_DN_RD: begin
            if (status.kid_in) cmd.rd_kids = 1'b1;
            else cmd.wr_carry = 1'b1;
         end
         ST_DN_CMP: begin
            if (status.dn_stop) cmd.wr_carry = 1'b1;
            else cmd.dn_step = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/tksh_dp.sv @@
`default_nettype none
module tksh_dp #(
   parameter int MAX_KEEP = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [tksh_pkg::VALUE_W-1:0] req_value,
   input  logic [tksh_pkg::KEEP_W-1:0]        keep_count,
   input  tksh_pkg::cmd_type                  cmd,
   output tksh_pkg::status_type               status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [tksh_pkg::VALUE_W-1:0] kept_value,
   output logic                               run_end
);
   import tksh_pkg::*;

   localparam int DEPTH = MAX_KEEP + 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_KEEP + 2);
   localparam int KW    = CW + 1;
   localparam int CMPW  = ((CW > KEEP_W) ? CW : KEEP_W) + 1;

   logic signed [VALUE_W-1:0] heap_mem [DEPTH];

   logic [CW-1:0]             fill_ff, fill_in;
   logic [AW-1:0]             pos_ff, pos_in;
   logic signed [VALUE_W-1:0] carry_ff, carry_in;
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]             rd_a_addr, rd_b_addr;
   logic                      wr_en;
   logic signed [VALUE_W-1:0] wr_data;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] kept_value_ff;
   logic                      run_end_ff;

   logic [AW-1:0]             parent;
   logic [KW-1:0]             kid, kid_b, fill_x;
   logic                      b_wins;
   logic signed [VALUE_W-1:0] kid_val;
   logic [AW-1:0]             kid_sel;

   assign parent  = AW'((pos_ff - AW'(1)) >> 1);
   assign kid     = KW'({pos_ff, 1'b1});
   assign kid_b   = kid + KW'(1);
   assign fill_x  = KW'(fill_ff);
   assign b_wins  = (kid_b < fill_x) && (rd_b_ff > rd_a_ff);
   assign kid_val = b_wins ? rd_b_ff : rd_a_ff;
   assign kid_sel = b_wins ? AW'(kid_b) : AW'(kid);

   assign status.pos_zero     = (pos_ff == '0);
   assign status.up_greater   = (carry_ff > rd_a_ff);
   assign status.kid_in       = (kid < fill_x);
   assign status.dn_stop      = (carry_ff > kid_val);
   assign status.over_limit   = (CMPW'(fill_ff) > CMPW'(keep_count)) ||
                                (CMPW'(fill_ff) > CMPW'(MAX_KEEP));
   assign status.fill_nonzero = (fill_ff != '0);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   // read address select
   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = '0;
      priority if (cmd.rd_parent) begin
         rd_a_addr = parent;
      end else if (cmd.pop_start) begin
         rd_a_addr = '0;
         rd_b_addr = AW'(fill_ff - CW'(1));
      end else if (cmd.rd_kids) begin
         rd_a_addr = AW'(kid);
         rd_b_addr = AW'(kid_b);
      end
   end

   // write select: every write lands on the hole at pos
   always_comb begin
      wr_en   = cmd.wr_carry || cmd.up_step || cmd.dn_step;
      wr_data = carry_ff;
      priority if (cmd.up_step) wr_data = rd_a_ff;
      else if (cmd.dn_step) wr_data = kid_val;
      else wr_data = carry_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) heap_mem[pos_ff] <= wr_data;
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   always_comb begin
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      carry_in = carry_ff;
      if (cmd.load_item) begin
         fill_in  = fill_ff + CW'(1);
         pos_in   = AW'(fill_ff);
         carry_in = req_value;
      end
      if (cmd.pop_start) fill_in = fill_ff - CW'(1);
      if (cmd.pop_load) begin
         pos_in   = '0;
         carry_in = rd_b_ff;
      end
      if (cmd.up_step) pos_in = parent;
      if (cmd.dn_step) pos_in = kid_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else fill_ff <= fill_in;
      pos_ff   <= pos_in;
      carry_ff <= carry_in;
   end

   // output word register
   assign rsp_valid_in = (cmd.pop_load && cmd.emit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (cmd.pop_load && cmd.emit) begin
         kept_value_ff <= rd_a_ff;
         run_end_ff    <= (fill_ff == '0);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign kept_value = kept_value_ff;
   assign run_end    = run_end_ff;

endmodule
`default_nettype wire

@@ rtl/top_k_smallest_heap_unit.sv @@
// Top-k smallest selector built on a binary max-heap.
// req_bus carries one signed value per word plus set_end. Each value goes in
// at the next leaf and sifts up; while the heap holds more than keep_count
// (capped at MAX_KEEP) values, the root is dropped and the last leaf sifts
// down. After the word marked set_end the heap is drained root first, so
// rsp_bus gives the kept values largest to smallest, run_end on the final
// one, and the heap is left empty. keep_count of zero drops every value.
// keep_count sits at byte address 0 of the csr_ port (reset 32); write it
// only while the block is idle.
// Structure: the heap is one memory with two registered read ports and one
// write port, and the sequencer spends a read state and a compare state on
// each heap level. An insert climbs at most 5 levels and each pop descends
// at most 5 (for MAX_KEEP of 32). req_bus.ready is high only between
// items. The first result word follows once the set_end insert and its
// trims finish, then one word per pop.
// A stalled rsp_bus holds the finished word in its register and pauses
// the drain before the next pop. Reset empties the heap (no clearing pass)
// and drops any pending result word.
`default_nettype none
module top_k_smallest_heap_unit #(
   parameter int MAX_KEEP = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   tksh_req_if.sink                      req_bus,
   tksh_rsp_if.source                    rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tksh_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tksh_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [tksh_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tksh_pkg::*;

   logic [KEEP_W-1:0] keep_count_ff, keep_count_in;
   logic              csr_write;
   logic              csr_hit;
   cmd_type           cmd;
   status_type        status;

   // Register file: one register, index taken from the word address bit.
   assign csr_hit   = (csr_paddr[ADDR_W-1] == CSR_IDX_KEEP);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      keep_count_in = keep_count_ff;
      if (csr_write && csr_hit) keep_count_in = csr_pwdata[KEEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) keep_count_ff <= KEEP_RESET;
      else keep_count_ff <= keep_count_in;
   end

   assign csr_prdata = csr_hit ? DATA_W'(keep_count_ff) : '0;

   // Sequencer: walks the heap one level at a time, with a read state and a compare state per level.
   tksh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_set_end (req_bus.set_end),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // Heap memory, fill count, hole position and output word register.
   tksh_dp #(
      .MAX_KEEP (MAX_KEEP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_bus.value),
      .keep_count (keep_count_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .kept_value (rsp_bus.kept_value),
      .run_end    (rsp_bus.run_end)
   );

endmodule
`default_nettype wire

@@ rtl/tksh_checker.sv @@
`default_nettype none
module tksh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tksh_pkg::VALUE_W-1:0] kept_value,
   input logic                               run_end
);
   import tksh_pkg::*;

   logic signed [VALUE_W-1:0] prev_value_ff;
   logic                      prev_open_ff;
   logic                      rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // track the last word taken and whether its run is still open
   always_ff @(posedge clock) begin
      if (reset) prev_open_ff <= 1'b0;
      else if (rsp_take) prev_open_ff <= !run_end;
      if (rsp_take) prev_value_ff <= kept_value;
   end

   a_reset_drops_word: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word survived reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(kept_value) && $stable(run_end))
      else $error("stalled result word changed");

   a_descending: assert property (@(posedge clock) disable iff (reset)
      rsp_take && prev_open_ff |-> kept_value <= prev_value_ff)
      else $error("run not in descending order");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while heap update in progress");

endmodule

bind top_k_smallest_heap_unit tksh_checker u_tksh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .kept_value (rsp_bus.kept_value),
   .run_end    (rsp_bus.run_end)
);
`default_nettype wire

@@ test/tksh_kept_checker.sv @@
module tksh_kept_checker #(
   parameter int MAX_KEEP = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [tksh_pkg::VALUE_W-1:0]  req_value,
   input  logic                          req_set_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [tksh_pkg::VALUE_W-1:0]  rsp_kept_value,
   input  logic                          rsp_run_end,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [tksh_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [tksh_pkg::DATA_W-1:0]   csr_pwdata,
   input  logic [tksh_pkg::DATA_W-1:0]   csr_prdata,
   output int                            fail_count,
   output int                            pending,
   output int                            kept_seen
);
   import tksh_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] kept;
      logic               last;
   } kept_word_type;

   // own copy of the heap and the keep register
   logic [VALUE_W-1:0] heap_mem [0:MAX_KEEP];
   int unsigned        heap_cnt;
   logic [KEEP_W-1:0]  keep_reg;
   kept_word_type      kept_due [$];

   function automatic bit above(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

   function automatic void swap_slots(input int unsigned a, input int unsigned b);
      logic [VALUE_W-1:0] t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
   endfunction

   function automatic void heap_push(input logic [VALUE_W-1:0] v);
      int unsigned pos;
      int unsigned up;
      if (heap_cnt > MAX_KEEP) return;
      pos           = heap_cnt;
      heap_mem[pos] = v;
      heap_cnt++;
      while (pos > 0) begin
         up = (pos - 1) / 2;
         if (!above(heap_mem[pos], heap_mem[up])) break;
         swap_slots(pos, up);
         pos = up;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] heap_pop_root();
      logic [VALUE_W-1:0] top_v;
      int unsigned        pos;
      int unsigned        kid;
      top_v = heap_mem[0];
      pos   = 0;
      heap_cnt--;
      heap_mem[0] = heap_mem[heap_cnt];
      while (2 * pos + 1 < heap_cnt) begin
         kid = 2 * pos + 1;
         if (kid + 1 < heap_cnt && above(heap_mem[kid + 1], heap_mem[kid])) kid++;
         if (above(heap_mem[pos], heap_mem[kid])) break;
         swap_slots(pos, kid);
         pos = kid;
      end
      return top_v;
   endfunction

   // insert, trim to the keep count, drain on set end
   function automatic void take_word(input logic [VALUE_W-1:0] v, input logic set_end);
      int unsigned   lim;
      kept_word_type w;
      lim = (keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg;
      heap_push(v);
      while (heap_cnt > lim) void'(heap_pop_root());
      if (set_end) begin
         while (heap_cnt > 0) begin
            w.kept = heap_pop_root();
            w.last = (heap_cnt == 0);
            kept_due.push_back(w);
         end
      end
   endfunction

   always @(posedge clock) begin
      kept_word_type w;
      if (reset) begin
         heap_cnt   = 0;
         keep_reg   = KEEP_RESET;
         kept_due.delete();
         fail_count = 0;
         kept_seen  = 0;
         pending    = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == CSR_IDX_KEEP) begin
            if (csr_pwrite) begin
               keep_reg = csr_pwdata[KEEP_W-1:0];
            end else if (csr_prdata !== DATA_W'(keep_reg)) begin
               $display("%0t keep_count read: expected %0d got %0d",
                        $time, keep_reg, csr_prdata);
               fail_count++;
            end
         end
         if (req_valid && req_ready) take_word(req_value, req_set_end);
         if (rsp_valid && rsp_ready) begin
            kept_seen++;
            if (kept_due.size() == 0) begin
               $display("%0t unexpected word: expected none got %0d run_end %0b",
                        $time, $signed(rsp_kept_value), rsp_run_end);
               fail_count++;
            end else begin
               w = kept_due.pop_front();
               if (rsp_kept_value !== w.kept) begin
                  $display("%0t kept_value: expected %0d got %0d",
                           $time, $signed(w.kept), $signed(rsp_kept_value));
                  fail_count++;
               end
               if (rsp_run_end !== w.last) begin
                  $display("%0t run_end: expected %0b got %0b", $time, w.last, rsp_run_end);
                  fail_count++;
               end
            end
         end
         pending = kept_due.size();
      end
   end

endmodule

@@ test/tb_top_k_smallest_heap_unit.sv @@
module tb_top_k_smallest_heap_unit;
   import tksh_pkg::*;

   localparam int MAX_KEEP = 32;
   localparam int WORD_GOAL = 370;
   localparam int HOLD_OFF_CYCLES = 600;
   // no result can come from a plain word, so let the sequencer settle
   // (one insert plus one trim pop, both at full depth) before a write
   localparam int SETTLE_CYCLES = 60;

   localparam logic [ADDR_W-1:0]  KEEP_ADDR  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0]  SPARE_ADDR = ADDR_W'(4);   // no register here
   localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0] VALUE_ZERO = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] VALUE_NEG1 = 32'hffff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_psel    = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr   = '0;
   logic [DATA_W-1:0]  csr_pwdata  = '0;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   int fail_count;
   int pending;
   int kept_seen;

   // sender and receiver pacing, shared between the stimulus and the sink
   bit src_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int rsp_hold_left = 0;

   int words_sent = 0;
   int sets_sent  = 0;
   int csr_writes = 0;
   logic [KEEP_W-1:0] keep_now = KEEP_RESET;

   tksh_req_if req_if ();
   tksh_rsp_if rsp_if ();

   always #6 clock = ~clock;

   top_k_smallest_heap_unit #(
      .MAX_KEEP (MAX_KEEP)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tksh_kept_checker #(
      .MAX_KEEP (MAX_KEEP)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_value      (req_if.value),
      .req_set_end    (req_if.set_end),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_kept_value (rsp_if.kept_value),
      .rsp_run_end    (rsp_if.run_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .kept_seen      (kept_seen)
   );

   // Hard stop: far beyond the slowest legal run (every set fully drained
   // against the longest stalls, plus the long hold-off).
   initial begin
      #20_000_000;
      $display("timed out with %0d kept words outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
   end

   // Result sink: drive ready at the falling edge. A requested hold-off is
   // counted down here, one at each falling edge; otherwise stall at
   // random about 22 times in 100 unless idling is switched off.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
         end else if (rsp_idle && $urandom_range(0, 99) < 22) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Mostly full-range values; some extremes, some from a narrow band so
   // that duplicates show up inside one set.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return VALUE_ZERO;
               default: return VALUE_NEG1;
            endcase
         end
         1, 2: return VALUE_W'($urandom_range(0, 15)) - VALUE_W'(8);
         default: return $urandom();
      endcase
   endfunction

   // Offer one word; called and returns at a falling edge. Hold valid high
   // across back-to-back words; drop it only for an idle cycle, so valid
   // never gets two assignments in one step.
   task automatic offer_value(input logic [VALUE_W-1:0] v, input logic set_end);
      while (src_idle && $urandom_range(0, 99) < 22) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.value   <= v;
      req_if.set_end <= set_end;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      words_sent++;
      if (set_end) sets_sent++;
   endtask

   // Offer a set of random values, set_end on the last unless left open.
   task automatic offer_set(input int len, input bit close_set);
      for (int i = 0; i < len; i++) offer_value(pick_value(), close_set && i == len - 1);
   endtask

   // Pause the sender until every expected word has come, then let the
   // sequencer finish any trim still in flight.
   task automatic await_drain();
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_writes++;
      if (addr == KEEP_ADDR) keep_now = data[KEEP_W-1:0];
   endtask

   // Read back; the checker compares prdata during the access cycle.
   task automatic csr_get(input logic [ADDR_W-1:0] addr);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Keep count with random junk above the register's six bits.
   task automatic set_keep(input logic [KEEP_W-1:0] kc);
      csr_put(KEEP_ADDR, {(DATA_W-KEEP_W)'($urandom()), kc});
      csr_get(KEEP_ADDR);
   endtask

   initial begin
      int phase;
      int len;
      logic [KEEP_W-1:0] kc;

      req_if.valid   = 1'b0;
      req_if.value   = '0;
      req_if.set_end = 1'b0;

      // hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reset keep count first: read it back, then a set
      // with both extremes, zero, minus one and a duplicate pair.
      csr_get(KEEP_ADDR);
      offer_value(VALUE_MIN, 1'b0);
      offer_value(VALUE_MAX, 1'b0);
      offer_value(VALUE_ZERO, 1'b0);
      offer_value(VALUE_NEG1, 1'b0);
      offer_value(32'd1, 1'b0);
      offer_value(32'd7, 1'b0);
      offer_value(32'd7, 1'b0);
      offer_value(-32'sd7, 1'b1);
      // a set of one word
      offer_value(32'd12345, 1'b1);
      await_drain();

      // keep count of zero: the set end gives nothing at all
      set_keep(KEEP_W'(0));
      offer_value(32'd99, 1'b1);
      await_drain();

      // write to an index with no register; keep count must stay zero
      csr_put(SPARE_ADDR, $urandom());
      csr_get(KEEP_ADDR);

      // keep one, with the smallest value duplicated
      set_keep(KEEP_W'(1));
      offer_value(32'd5, 1'b0);
      offer_value(-32'sd3, 1'b0);
      offer_value(32'd9, 1'b0);
      offer_value(-32'sd3, 1'b1);
      await_drain();

      // lower the keep count in the middle of a set
      set_keep(KEEP_W'(32));
      offer_set(6, 1'b0);
      await_drain();
      set_keep(KEEP_W'(2));
      offer_value(VALUE_ZERO, 1'b1);

      // Random phases, each with its own keep count: saturated, zero, just over
      // the maximum, one, exactly the maximum, random ones in between, and fully random ones.
      phase = 0;
      while (words_sent < WORD_GOAL) begin
         await_drain();
         case (phase % 7)
            0: kc = KEEP_W'(63);
            1: kc = KEEP_W'(0);
            2: kc = KEEP_W'(33);
            3: kc = KEEP_W'(1);
            4: kc = KEEP_W'(32);
            5: kc = KEEP_W'($urandom_range(2, 31));
            default: kc = KEEP_W'($urandom_range(0, 63));
         endcase
         set_keep(kc);

         // one phase runs with no idling on either side
         src_idle = (phase != 2);
         rsp_idle = (phase != 2);

         // stall the sink long enough that the drain backs up into req_bus
         if (phase == 4) rsp_hold_left = HOLD_OFF_CYCLES;

         repeat ($urandom_range(2, 4)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 45) : $urandom_range(1, 12);
            offer_set(len, 1'b1);
         end

         // now and then leave a set open and shrink the keep count under it
         if ($urandom_range(0, 4) == 0) begin
            offer_set($urandom_range(4, 20), 1'b0);
            await_drain();
            set_keep(KEEP_W'($urandom_range(0, keep_now)));
            offer_value(pick_value(), 1'b1);
         end
         phase++;
      end

      // drain everything and give the block time to show any stray word
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("covered %0d words in %0d sets over %0d keep-count phases",
               words_sent, sets_sent, phase);
      $display("checked %0d kept words, %0d register writes", kept_seen, csr_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tksh_pkg.sv
rtl/tksh_if.sv
rtl/tksh_ctrl.sv
rtl/tksh_dp.sv
rtl/top_k_smallest_heap_unit.sv
rtl/tksh_checker.sv
test/tksh_kept_checker.sv
test/tb_top_k_smallest_heap_unit.sv
